// ===== rtl/core/mfb_pkg.sv =====
// Shared types, codes and constants of the frame store refresher.
package mfb_pkg;

    localparam int SCREEN_COLUMNS     = 128;
    localparam int SCREEN_PAGES_COUNT = 8;
    localparam int ROWS_PER_PAGE      = 8;

    localparam logic [7:0] CONTROL_DATA         = 8'h40;
    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd60;

    typedef enum logic [1:0] {
        OP_PIXEL    = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_REFRESH  = 2'd2,
        OP_BUS_DONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_SEND  = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef struct packed {
        t_op        operation;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
    } t_in_item;

    typedef struct packed {
        t_action    bus_action;
        logic [7:0] bus_byte;
        logic       transfer_busy;
    } t_out_item;

    typedef struct packed {
        logic step;
        t_op  op;
    } t_seq_cmd;

endpackage

// ===== rtl/core/mfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mfb_pkg::SCREEN_COLUMNS * mfb_pkg::SCREEN_PAGES_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mfb_seq.sv =====
// Bus refresh sequencer: phase, byte counter, pending flag and device address.
module mfb_seq #(
    parameter int STORE_BYTES = mfb_pkg::SCREEN_COLUMNS * mfb_pkg::SCREEN_PAGES_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfb_pkg::t_seq_cmd              i_cmd,
    input  logic [7:0]                     i_rd_data,
    input  logic                           i_cfg_we,
    input  logic [6:0]                     i_cfg_data,
    output mfb_pkg::t_out_item             o_result,
    output logic [$clog2(STORE_BYTES)-1:0] o_byte_index
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam logic [CW-1:0] STORE_END = CW'(STORE_BYTES);

    typedef enum logic [5:0] {
        PH_ADDR   = 6'b000001,
        PH_CTRL   = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_STOP   = 6'b001000,
        PH_DECIDE = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pending, n_pending;
    logic          r_active, n_active;
    logic [6:0]    r_dev_addr;
    logic [CW-1:0] cnt_inc;

    mfb_pkg::t_action action;
    logic [7:0]       bus_byte;

    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_pending = r_pending;
        n_active  = r_active;
        action    = mfb_pkg::ACT_NONE;
        bus_byte  = 8'd0;
        unique case (i_cmd.op) inside
            mfb_pkg::OP_CLEAR, mfb_pkg::OP_REFRESH: begin
                n_pending = 1'b1;
                if (!r_active) begin
                    n_active = 1'b1;
                    n_phase  = PH_ADDR;
                    action   = mfb_pkg::ACT_START;
                end
            end
            mfb_pkg::OP_BUS_DONE: begin
                if (r_active) begin
                    unique case (r_phase)
                        PH_ADDR: begin
                            action   = mfb_pkg::ACT_SEND;
                            bus_byte = {r_dev_addr, 1'b0};
                            n_phase  = PH_CTRL;
                        end
                        PH_CTRL: begin
                            action    = mfb_pkg::ACT_SEND;
                            bus_byte  = mfb_pkg::CONTROL_DATA;
                            n_cnt     = '0;
                            n_pending = 1'b0;
                            n_phase   = PH_DATA;
                        end
                        PH_DATA: begin
                            action   = mfb_pkg::ACT_SEND;
                            bus_byte = i_rd_data;
                            n_cnt    = cnt_inc;
                            if (cnt_inc >= STORE_END) begin
                                n_phase = PH_STOP;
                            end
                        end
                        PH_STOP: begin
                            action  = mfb_pkg::ACT_STOP;
                            n_phase = PH_DECIDE;
                        end
                        PH_DECIDE: begin
                            if (r_pending) begin
                                n_phase = PH_ADDR;
                                action  = mfb_pkg::ACT_START;
                            end else begin
                                n_phase  = PH_DONE;
                                n_active = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ADDR;
            r_cnt      <= '0;
            r_pending  <= 1'b0;
            r_active   <= 1'b0;
            r_dev_addr <= mfb_pkg::DEVICE_ADDRESS_RESET;
        end else begin
            if (i_cmd.step) begin
                r_phase   <= n_phase;
                r_cnt     <= n_cnt;
                r_pending <= n_pending;
                r_active  <= n_active;
            end
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_data;
            end
        end
    end

    assign o_result.bus_action    = action;
    assign o_result.bus_byte      = bus_byte;
    assign o_result.transfer_busy = n_active;
    assign o_byte_index           = r_cnt[AW-1:0];

endmodule

// ===== rtl/core/mono_framebuffer_bus_refresher.sv =====
// Top level: monochrome frame store with bus refresh sequencer.
// Each item is accepted in S_IDLE, which issues the frame memory read, and completed
// in S_EXEC, which modifies, writes back and loads the result register once the
// output register can take it; the single frame memory has a registered read. After
// reset, and after each clear item, the store is swept to zero one byte a cycle, all
// COLUMNS*PAGES bytes (1024 by default), during which no item is accepted;
// configuration writes are always taken. A result waiting in the output register
// does not block the next accept, only the completion of that item.
module mono_framebuffer_bus_refresher #(
    parameter int COLUMNS = mfb_pkg::SCREEN_COLUMNS,
    parameter int PAGES   = mfb_pkg::SCREEN_PAGES_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mfb_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mfb_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data
);

    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int ROWS        = PAGES * mfb_pkg::ROWS_PER_PAGE;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    mfb_pkg::t_in_item  r_item;
    mfb_pkg::t_out_item r_out;
    mfb_pkg::t_out_item seq_result;
    mfb_pkg::t_seq_cmd  seq_cmd;
    logic               r_out_valid;
    logic [AW-1:0]      r_rd_addr;
    logic               r_pix_ok;
    logic [AW-1:0]      r_clr_addr;

    logic          accept;
    logic          go;
    logic [AW-1:0] byte_index;
    logic [AW-1:0] pix_addr;
    logic [13:0]   pix_wide;
    logic          pix_ok;
    logic [AW-1:0] ram_raddr;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          ram_we;
    logic [7:0]    pix_mask;

    assign pix_ok = ({1'b0, i_in_item.pixel_x} < 9'(COLUMNS))
                 && ({1'b0, i_in_item.pixel_y} < 9'(ROWS));
    assign pix_wide = 14'(i_in_item.pixel_y[7:3]) * 14'(COLUMNS)
                    + 14'(i_in_item.pixel_x);
    assign pix_addr = pix_wide[AW-1:0];

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign go     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign ram_raddr = (r_state == S_IDLE) ?
                       ((i_in_item.operation == mfb_pkg::OP_BUS_DONE) ? byte_index : pix_addr)
                       : r_rd_addr;

    assign pix_mask = 8'(1) << r_item.pixel_y[2:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_addr;
        ram_wdata = r_item.pixel_on ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 8'd0;
        end else if (go && r_pix_ok && (r_item.operation == mfb_pkg::OP_PIXEL)) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go) begin
                    n_state = (r_item.operation == mfb_pkg::OP_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= (r_clr_addr == LAST_ADDR) ? '0 : r_clr_addr + 1'b1;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_in_item;
            r_rd_addr <= ram_raddr;
            r_pix_ok  <= pix_ok;
        end
        if (go) begin
            r_out <= seq_result;
        end
    end

    assign seq_cmd.step = go;
    assign seq_cmd.op   = r_item.operation;

    mfb_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mfb_seq #(
        .STORE_BYTES(STORE_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (seq_cmd),
        .i_rd_data   (ram_rdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_result    (seq_result),
        .o_byte_index(byte_index)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
